/* hdl/tpd_pkg.sv */
`timescale 1ns / 1ps
package tpd_pkg;

  localparam int CW   = 16;          // coordinate width
  localparam int VW   = CW + 1;      // edge vector component
  localparam int PW   = 2 * VW;      // component product
  localparam int DW   = PW + 2;      // dot product, sum of three
  localparam int NW   = PW + 1;      // normal component, difference of two
  localparam int HW   = DW / 2;      // half of a dot product for split multiply
  localparam int MW   = 2 * DW;      // full product of two dot products
  localparam int RW   = MW + 4;      // barycentric sums
  localparam int PDW  = VW + NW;     // depth numerator term
  localparam int NUMW = PDW + 2;     // depth numerator
  localparam int FRAC = 8;           // depth fraction bits
  localparam int TW   = NUMW + FRAC + 1; // rounded dividend
  localparam int QW   = 32;          // quotient and depth width

  localparam int FRONT    = 7;
  localparam int N_STAGES = FRONT + QW + 1;

  localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

  // dot product operands: d00, d01, d02, d11, d12 over v0, v1, v2
  localparam int DOT_A [5] = '{0, 0, 0, 1, 1};
  localparam int DOT_B [5] = '{0, 1, 2, 1, 2};
  // wide products: d00*d11, d01*d01, d11*d02, d01*d12, d00*d12, d01*d02
  localparam int WIDE_A [6] = '{0, 1, 3, 1, 0, 1};
  localparam int WIDE_B [6] = '{3, 1, 2, 4, 4, 2};

  typedef struct packed {
    logic signed [2*HW-1:0] hh;
    logic signed [2*HW:0]   hl;
    logic signed [2*HW:0]   lh;
    logic        [2*HW-1:0] ll;
  } pp_t;

  typedef struct packed {
    logic [4:0][DW-1:0] d;
    logic [NW-1:0]      nx;
    logic [NW-1:0]      ny;
    logic [NW-1:0]      nz;
    logic [VW-1:0]      dx;
    logic [VW-1:0]      dy;
    logic [CW-1:0]      az;
  } geom_t;

  typedef struct packed {
    logic          hit;
    logic          nzero;
    logic          neg;
    logic          ovf;
    logic [NW-1:0] dmag;
    logic [TW-1:0] t;
  } wres_t;

  typedef struct packed {
    logic          hit;
    logic [QW-1:0] depth;
    logic          dvalid;
  } res_t;

  function automatic pp_t pp_split(input logic signed [DW-1:0] a,
                                   input logic signed [DW-1:0] b);
    pp_t r;
    logic signed [HW-1:0] ah;
    logic signed [HW-1:0] bh;
    logic signed [HW:0]   al;
    logic signed [HW:0]   bl;
    ah = a[DW-1:HW];
    bh = b[DW-1:HW];
    al = $signed({1'b0, a[HW-1:0]});
    bl = $signed({1'b0, b[HW-1:0]});
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = a[HW-1:0] * b[HW-1:0];
    return r;
  endfunction

  function automatic logic signed [MW-1:0] pp_join(input pp_t p);
    logic signed [MW-1:0] hh;
    logic signed [MW-1:0] mid;
    logic signed [MW-1:0] ll;
    hh  = {{(MW-2*HW){p.hh[2*HW-1]}}, p.hh};
    mid = {{(MW-2*HW-1){p.hl[2*HW]}}, p.hl} + {{(MW-2*HW-1){p.lh[2*HW]}}, p.lh};
    ll  = {{(MW-2*HW){1'b0}}, p.ll};
    return (hh <<< (2*HW)) + (mid <<< HW) + ll;
  endfunction

endpackage

/* hdl/triangle_point_test_and_depth_core.sv */
`timescale 1ns / 1ps
// channel | direction | handshake             | word
// in_     | input     | in_valid / in_stall   | vertices a, b, c and point, 16-bit signed
// out_    | output    | out_valid / out_stall | inside_res, depth (Q23.8), depth_valid
//
// One word accepted per cycle while in_stall is low.
// Pipeline depth is 40 stages: 7 arithmetic stages, 32 divider
// stages (one quotient bit each) and a saturation stage.
// rst_n is synchronous, active low, and clears only valid and skid control.
// The pipeline moves as one; a skid register behind the output register
// lets the pipe advance on while out is stalled until it fills, then in_stall rises.
module triangle_point_test_and_depth_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_a_x,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_a_y,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_a_z,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_b_x,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_b_y,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_b_z,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_c_x,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_c_y,
  input  logic signed [tpd_pkg::CW-1:0]  in_vertex_c_z,
  input  logic signed [tpd_pkg::CW-1:0]  in_point_x,
  input  logic signed [tpd_pkg::CW-1:0]  in_point_y,
  input  logic signed [tpd_pkg::CW-1:0]  in_point_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_inside_res,
  output logic signed [tpd_pkg::QW-1:0]  out_depth,
  output logic                           out_depth_valid
);
  import tpd_pkg::*;

  logic [11:0][CW-1:0] crd;
  geom_t               geo;
  wres_t               wres;
  res_t                res;

  logic [N_STAGES:1]   v_r;      // valid bit per pipeline stage
  logic                adv;      // whole pipe advances
  logic                out_valid_r, skid_v_r;
  res_t                out_r, skid_r;
  logic                o_hold, o_from_skid, o_from_pipe, s_load;

  assign crd = {in_point_z, in_point_y, in_point_x,
                in_vertex_c_z, in_vertex_c_y, in_vertex_c_x,
                in_vertex_b_z, in_vertex_b_y, in_vertex_b_x,
                in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};

  // pipe is free while the skid register is empty
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  tpd_geom u_geom (
    .clk (clk),
    .en  (adv),
    .crd (crd),
    .geo (geo)
  );

  tpd_wide u_wide (
    .clk  (clk),
    .en   (adv),
    .geo  (geo),
    .wres (wres)
  );

  tpd_div u_div (
    .clk  (clk),
    .en   (adv),
    .wres (wres),
    .res  (res)
  );

  // output register keeps its word under stall; a finishing word goes to skid
  assign o_hold      = out_valid_r && out_stall;
  assign s_load      = o_hold && adv && v_r[N_STAGES];
  assign o_from_skid = !o_hold && skid_v_r;
  assign o_from_pipe = !o_hold && !skid_v_r && adv && v_r[N_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= {v_r[N_STAGES-1:1], in_valid};
      end
      if (s_load) begin
        skid_v_r <= 1'b1;
      end else if (o_from_skid) begin
        skid_v_r <= 1'b0;
      end
      if (!o_hold) begin
        out_valid_r <= o_from_skid || o_from_pipe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      skid_r <= res;
    end
    if (o_from_skid) begin
      out_r <= skid_r;
    end else if (o_from_pipe) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inside_res  = out_r.hit;
  assign out_depth       = $signed(out_r.depth);
  assign out_depth_valid = out_r.dvalid;

  a_depth_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_depth_valid) |-> (out_depth == '0))
    else $error("invalid depth not forced to zero");

  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_skid_catch : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && v_r[N_STAGES] && !skid_v_r) |=> skid_v_r)
    else $error("finishing word not caught by skid");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[1])
    else $error("accepted word missing from first stage");

endmodule

/* hdl/tpd_geom.sv */
`timescale 1ns / 1ps
// Stages 1-3: edge vectors, component products, dot products and normal.
module tpd_geom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [11:0][tpd_pkg::CW-1:0] crd,
  output tpd_pkg::geom_t               geo
);
  import tpd_pkg::*;

  logic signed [VW-1:0] v_r [3][3];
  logic signed [VW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic signed [CW-1:0] az1_r, az2_r, az3_r;
  logic signed [PW-1:0] dp_r [5][3];
  logic signed [PW-1:0] np_r [6];
  logic signed [DW-1:0] d_r [5];
  logic signed [NW-1:0] nx_r, ny_r, nz_r;

  function automatic logic signed [VW-1:0] sub_ext(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y);
    return {x[CW-1], x} - {y[CW-1], y};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v_r[0][i] <= sub_ext(crd[6+i], crd[i]);
        v_r[1][i] <= sub_ext(crd[3+i], crd[i]);
        v_r[2][i] <= sub_ext(crd[9+i], crd[i]);
      end
      dx1_r <= sub_ext(crd[0], crd[9]);
      dy1_r <= sub_ext(crd[1], crd[10]);
      az1_r <= crd[2];

      for (int j = 0; j < 5; j++) begin
        for (int i = 0; i < 3; i++) begin
          dp_r[j][i] <= v_r[DOT_A[j]][i] * v_r[DOT_B[j]][i];
        end
      end
      np_r[0] <= v_r[1][1] * v_r[0][2];
      np_r[1] <= v_r[0][1] * v_r[1][2];
      np_r[2] <= v_r[0][0] * v_r[1][2];
      np_r[3] <= v_r[1][0] * v_r[0][2];
      np_r[4] <= v_r[1][0] * v_r[0][1];
      np_r[5] <= v_r[0][0] * v_r[1][1];
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      az2_r <= az1_r;

      for (int j = 0; j < 5; j++) begin
        d_r[j] <= DW'(dp_r[j][0]) + DW'(dp_r[j][1]) + DW'(dp_r[j][2]);
      end
      nx_r  <= NW'(np_r[0]) - NW'(np_r[1]);
      ny_r  <= NW'(np_r[2]) - NW'(np_r[3]);
      nz_r  <= NW'(np_r[4]) - NW'(np_r[5]);
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      az3_r <= az2_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      geo.d[j] = d_r[j];
    end
    geo.nx = nx_r;
    geo.ny = ny_r;
    geo.nz = nz_r;
    geo.dx = dx3_r;
    geo.dy = dy3_r;
    geo.az = az3_r;
  end

endmodule

/* hdl/tpd_wide.sv */
`timescale 1ns / 1ps
// Stages 4-7: split wide products, barycentric compare, depth dividend.
module tpd_wide (
  input  logic           clk,
  input  logic           en,
  input  tpd_pkg::geom_t geo,
  output tpd_pkg::wres_t wres
);
  import tpd_pkg::*;

  pp_t                    pp_r [6];
  logic signed [PDW-1:0]  pd_r [3];
  logic signed [NW-1:0]   nz4_r, nz5_r;
  logic signed [MW-1:0]   pr_r [6];
  logic signed [NUMW-1:0] num_r;
  logic signed [RW-1:0]   den_r, u_r, vv_r;
  logic [TW-1:0]          n6_r;
  logic [NW-1:0]          dm6_r;
  logic                   neg6_r, zero6_r;
  wres_t                  w7_r;

  logic [NUMW-1:0]        mag_c;
  logic signed [RW-1:0]   rest_c;
  logic [TW-1:0]          t_c;

  always_comb begin
    mag_c  = num_r[NUMW-1] ? NUMW'(-num_r) : NUMW'(num_r);
    rest_c = u_r + vv_r - den_r;
    t_c    = n6_r + TW'(dm6_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        pp_r[j] <= pp_split($signed(geo.d[WIDE_A[j]]), $signed(geo.d[WIDE_B[j]]));
      end
      pd_r[0] <= $signed(geo.dx) * $signed(geo.nx);
      pd_r[1] <= $signed(geo.dy) * $signed(geo.ny);
      pd_r[2] <= $signed(geo.az) * $signed(geo.nz);
      nz4_r   <= $signed(geo.nz);

      for (int j = 0; j < 6; j++) begin
        pr_r[j] <= pp_join(pp_r[j]);
      end
      num_r <= NUMW'(pd_r[0]) + NUMW'(pd_r[1]) + NUMW'(pd_r[2]);
      nz5_r <= nz4_r;

      den_r   <= RW'(pr_r[0]) - RW'(pr_r[1]);
      u_r     <= RW'(pr_r[2]) - RW'(pr_r[3]);
      vv_r    <= RW'(pr_r[4]) - RW'(pr_r[5]);
      n6_r    <= {{(TW-NUMW-FRAC){1'b0}}, mag_c, {FRAC{1'b0}}};
      dm6_r   <= nz5_r[NW-1] ? NW'(-nz5_r) : NW'(nz5_r);
      neg6_r  <= num_r[NUMW-1] ^ nz5_r[NW-1];
      zero6_r <= (nz5_r == '0);

      w7_r.hit    <= !den_r[RW-1] && (den_r != '0) && !u_r[RW-1] && (u_r != '0) &&
                     !vv_r[RW-1] && (vv_r != '0) && rest_c[RW-1];
      w7_r.nzero  <= zero6_r;
      w7_r.neg    <= neg6_r;
      // quotient would need more than QW bits: saturates either way
      w7_r.ovf    <= ({{(NW-TW+QW){1'b0}}, t_c[TW-1:QW]} >= dm6_r);
      w7_r.dmag   <= dm6_r;
      w7_r.t      <= t_c;
    end
  end

  assign wres = w7_r;

endmodule

/* hdl/tpd_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, then saturation stage.
module tpd_div (
  input  logic           clk,
  input  logic           en,
  input  tpd_pkg::wres_t wres,
  output tpd_pkg::res_t  res
);
  import tpd_pkg::*;

  typedef struct packed {
    logic hit;
    logic nzero;
    logic neg;
    logic ovf;
  } flg_t;

  logic [NW-1:0] rem_r [QW];
  logic [NW-1:0] dm_r  [QW];
  logic [QW-1:0] q_r   [QW];
  logic [QW-1:0] tl_r  [QW];
  flg_t          fl_r  [QW];
  res_t          res_r;

  logic [NW-1:0] rem_p [QW];
  logic [NW-1:0] dm_p  [QW];
  logic [QW-1:0] q_p   [QW];
  logic [QW-1:0] tl_p  [QW];
  flg_t          fl_p  [QW];
  logic [NW:0]   rs_c  [QW];
  logic [NW:0]   df_c  [QW];
  logic          ge_c  [QW];

  logic [QW-1:0] qf_c;
  logic [QW-1:0] mag_c;
  res_t          res_c;

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_p[j] = {{(NW-TW+QW){1'b0}}, wres.t[TW-1:QW]};
        dm_p[j]  = wres.dmag;
        q_p[j]   = '0;
        tl_p[j]  = wres.t[QW-1:0];
        fl_p[j]  = '{hit: wres.hit, nzero: wres.nzero, neg: wres.neg, ovf: wres.ovf};
      end else begin
        rem_p[j] = rem_r[j-1];
        dm_p[j]  = dm_r[j-1];
        q_p[j]   = q_r[j-1];
        tl_p[j]  = tl_r[j-1];
        fl_p[j]  = fl_r[j-1];
      end
      rs_c[j] = {rem_p[j], tl_p[j][QW-1]};
      df_c[j] = rs_c[j] - {1'b0, dm_p[j]};
      ge_c[j] = (rs_c[j] >= {1'b0, dm_p[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_r[j] <= ge_c[j] ? df_c[j][NW-1:0] : rs_c[j][NW-1:0];
        dm_r[j]  <= dm_p[j];
        q_r[j]   <= {q_p[j][QW-2:0], ge_c[j]};
        tl_r[j]  <= {tl_p[j][QW-2:0], 1'b0};
        fl_r[j]  <= fl_p[j];
      end
      res_r <= res_c;
    end
  end

  always_comb begin
    qf_c  = q_r[QW-1];
    mag_c = (fl_r[QW-1].ovf || (qf_c > SAT_NEG)) ? SAT_NEG : qf_c;
    res_c.hit    = fl_r[QW-1].hit;
    res_c.dvalid = !fl_r[QW-1].nzero;
    if (fl_r[QW-1].nzero) begin
      res_c.depth = '0;
    end else if (fl_r[QW-1].neg) begin
      res_c.depth = -mag_c;
    end else begin
      res_c.depth = (fl_r[QW-1].ovf || (qf_c > SAT_POS)) ? SAT_POS : qf_c;
    end
  end

  assign res = res_r;

endmodule

/* tb/triangle_point_test_and_depth_core_tb.sv */
`timescale 1ns / 1ps
module triangle_point_test_and_depth_core_tb;
  import tpd_pkg::*;

  // One input word: twelve coordinates in port order
  // (a.x a.y a.z b.x b.y b.z c.x c.y c.z p.x p.y p.z).
  typedef logic [11:0][15:0] tri_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tri_word_t in_word;
  logic out_valid;
  logic out_stall;
  logic out_inside_res;
  logic signed [QW-1:0] out_depth;
  logic out_depth_valid;

  tri_word_t pending_words[$];
  res_t expected_hits[$];
  int error_count;
  int cycle_count;
  int sent_count;
  int checked_count;

  triangle_point_test_and_depth_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_vertex_a_x(in_word[0]),
    .in_vertex_a_y(in_word[1]),
    .in_vertex_a_z(in_word[2]),
    .in_vertex_b_x(in_word[3]),
    .in_vertex_b_y(in_word[4]),
    .in_vertex_b_z(in_word[5]),
    .in_vertex_c_x(in_word[6]),
    .in_vertex_c_y(in_word[7]),
    .in_vertex_c_z(in_word[8]),
    .in_point_x(in_word[9]),
    .in_point_y(in_word[10]),
    .in_point_z(in_word[11]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_inside_res(out_inside_res),
    .out_depth(out_depth),
    .out_depth_valid(out_depth_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact point test and plane depth at full width.
  function automatic res_t predict_hit(tri_word_t w);
    longint a[3];
    longint b[3];
    longint c[3];
    longint p[3];
    longint e0[3];
    longint e1[3];
    longint e2[3];
    logic signed [127:0] d00, d01, d02, d11, d12, den, uu, vv;
    longint nx, ny, nz, num;
    logic [127:0] mag_num, mag_nz, quot;
    res_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(w[i]);
      b[i] = $signed(w[3+i]);
      c[i] = $signed(w[6+i]);
      p[i] = $signed(w[9+i]);
      e0[i] = c[i] - a[i];
      e1[i] = b[i] - a[i];
      e2[i] = p[i] - a[i];
    end
    d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    d02 = e0[0]*e2[0] + e0[1]*e2[1] + e0[2]*e2[2];
    d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d12 = e1[0]*e2[0] + e1[1]*e2[1] + e1[2]*e2[2];
    den = d00*d11 - d01*d01;
    uu = d11*d02 - d01*d12;
    vv = d00*d12 - d01*d02;
    r.hit = (den > 0) && (uu > 0) && (vv > 0) && (uu + vv < den);

    nx = e1[1]*e0[2] - e0[1]*e1[2];
    ny = e0[0]*e1[2] - e1[0]*e0[2];
    nz = e1[0]*e0[1] - e0[0]*e1[1];
    if (nz == 0) begin
      r.depth = '0;
      r.dvalid = 1'b0;
    end else begin
      num = a[0]*nx + a[1]*ny + a[2]*nz - p[0]*nx - p[1]*ny;
      mag_num = (num < 0) ? -num : num;
      mag_nz = (nz < 0) ? -nz : nz;
      // round half away from zero on the magnitude
      quot = (mag_num * 256 + mag_nz / 2) / mag_nz;
      if ((num < 0) != (nz < 0)) begin
        if (quot > 128'h8000_0000) quot = 128'h8000_0000;
        r.depth = -quot[QW-1:0];
      end else begin
        if (quot > 128'h7FFF_FFFF) quot = 128'h7FFF_FFFF;
        r.depth = quot[QW-1:0];
      end
      r.dvalid = 1'b1;
    end
    return r;
  endfunction

  function automatic tri_word_t pack_word(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int px, int py, int pz);
    tri_word_t w;
    w = {16'(pz), 16'(py), 16'(px), 16'(cz), 16'(cy), 16'(cx),
         16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Idle pattern: roughly 30% gaps, but a recurring quiet window
  // where neither side idles at all.
  function automatic bit idle_now();
    return ((cycle_count % 4000) >= 800) && ($urandom_range(99) < 30);
  endfunction

  // Driver: moves to the next word once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (in_valid && !in_stall)
        expected_hits.push_back(predict_hit(in_word));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && !idle_now()) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: sink stalls at random, each taken word checked in order.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected word, depth", out_depth, 0);
        end else begin
          want = expected_hits.pop_front();
          checked_count++;
          if (out_inside_res !== want.hit)
            report_mismatch("inside_res", out_inside_res, want.hit);
          if (out_depth !== want.depth)
            report_mismatch("depth", out_depth, $signed(want.depth));
          if (out_depth_valid !== want.dvalid)
            report_mismatch("depth_valid", out_depth_valid, want.dvalid);
        end
      end
    end
  end

  initial begin
    int ax, ay, az, bx, by, bz, cx, cy, cz, span;
    tri_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    error_count = 0;
    cycle_count = 0;
    checked_count = 0;
    sent_count = 0;

    // directed: extremes of every field
    pending_words.push_back('0);
    pending_words.push_back({12{16'h7FFF}});
    pending_words.push_back({12{16'h8000}});
    pending_words.push_back({6{16'h7FFF, 16'h8000}});
    pending_words.push_back({6{16'h8000, 16'h7FFF}});
    // largest triangle, point near its centroid
    pending_words.push_back(pack_word(-32768, -32768, 32767, 32767, -32768, -32768,
                                      -32768, 32767, 0, -10923, -10923, 0));
    // collinear and coincident vertices
    pending_words.push_back(pack_word(0, 0, 0, 5, 5, 5, 10, 10, 10, 3, 3, 3));
    pending_words.push_back(pack_word(7, -7, 3, 7, -7, 3, 7, -7, 3, 7, -7, 3));
    // point on a vertex, on an edge, plainly inside
    pending_words.push_back(pack_word(0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0));
    pending_words.push_back(pack_word(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 0, 0));
    pending_words.push_back(pack_word(0, 0, 0, 100, 0, 0, 0, 100, 0, 20, 20, 0));
    pending_words.push_back(pack_word(0, 0, 0, 100, 0, 0, 0, 100, 0, 20, 20, -900));
    // vertical plane: projected normal zero
    pending_words.push_back(pack_word(0, 0, 0, 10, 10, 50, 20, 20, -40, 10, 10, 0));
    // steep planes: depth saturates both ways
    pending_words.push_back(pack_word(0, 0, 0, 1, 0, 32767, 0, 1, 32767,
                                      32767, 32767, 0));
    pending_words.push_back(pack_word(0, 0, 0, 1, 0, -32768, 0, 1, -32768,
                                      32767, 32767, 0));
    // exact rounding ties, both signs
    pending_words.push_back(pack_word(0, 0, 0, 512, 0, 1, 0, 1, 0, 1, 0, 0));
    pending_words.push_back(pack_word(0, 0, 0, 512, 0, -1, 0, 1, 0, 1, 0, 0));
    pending_words.push_back(pack_word(0, 0, 0, 512, 0, 3, 0, 1, 0, 1, 0, 0));
    // swapped winding, point inside
    pending_words.push_back(pack_word(0, 0, 0, 0, 100, 30, 100, 0, -30, 20, 20, 5));

    // random: mostly triangles with a point near the centroid, some wild words
    repeat (1600) begin
      if ($urandom_range(99) < 25) begin
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(2, 12));
        ax = $urandom_range(2 * span) - span;
        ay = $urandom_range(2 * span) - span;
        az = $urandom_range(2 * span) - span;
        bx = $urandom_range(2 * span) - span;
        by = $urandom_range(2 * span) - span;
        bz = $urandom_range(2 * span) - span;
        cx = $urandom_range(2 * span) - span;
        cy = $urandom_range(2 * span) - span;
        cz = $urandom_range(2 * span) - span;
        w = pack_word(ax, ay, az, bx, by, bz, cx, cy, cz,
                      (ax + bx + cx) / 3 + int'($urandom_range(8)) - 4,
                      (ay + by + cy) / 3 + int'($urandom_range(8)) - 4,
                      (az + bz + cz) / 3 + int'($urandom_range(64)) - 32);
        if ($urandom_range(9) == 0)
          w[9] = w[$urandom_range(2) * 3];
      end
      pending_words.push_back(w);
    end
    sent_count = pending_words.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // every word sent must come back and be checked
    wait (checked_count == sent_count);
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("triangle_point_test_and_depth_core_tb: clean");
    else
      $display("triangle_point_test_and_depth_core_tb: errors");
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("triangle_point_test_and_depth_core_tb: errors");
    $finish;
  end

endmodule
